@@ hw/rtl/mesh_vertex_normal_engine_assert.svh @@
// Assertion macros for the mesh vertex normal engine
`ifndef MESH_VERTEX_NORMAL_ENGINE_ASSERT_SVH
`define MESH_VERTEX_NORMAL_ENGINE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define MVNE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent
`define MVNE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/mvne_pkg.sv @@
// Shared types, codes and constants of the mesh vertex normal engine
`timescale 1ns / 1ps
`default_nettype none
package mvne_pkg;

   localparam int MAX_VERTICES_DEF = 256;
   localparam int COORD_BITS_DEF   = 16;

   localparam int IDX_W   = 8;
   localparam int FIELD_W = 16;
   localparam int SUM_W   = 24;
   localparam int CNT_W   = 8;
   localparam int MUL_W   = 32;
   localparam int SQ_W    = 62;
   localparam int SQ_TOP  = 60;
   localparam int MAG_LIM = 30;
   localparam int NORM_SH = 15;
   localparam int QUO_W   = 16;
   localparam int NUM_W   = 47;
   localparam int DEN_W   = 33;
   localparam int REM_W   = 34;
   localparam int LEN_W   = 32;

   localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_TRI  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   localparam logic KIND_FACE   = 1'b0;
   localparam logic KIND_VERTEX = 1'b1;

   typedef struct packed {
      logic [1:0]                  op;
      logic [IDX_W-1:0]            idx;
      logic                        idx_ok;
      logic [2:0][IDX_W-1:0]       corner;
      logic [2:0]                  corner_ok;
      logic [2:0][FIELD_W-1:0]     pos;
   } cmd_type;

   typedef struct packed {
      logic                        kind;
      logic [2:0][FIELD_W-1:0]     normal;
      logic                        degenerate;
      logic                        unused_vertex;
   } rsp_type;

endpackage
`default_nettype wire

@@ hw/rtl/mvne_req_if.sv @@
// Request channel interface of the mesh vertex normal engine
`timescale 1ns / 1ps
`default_nettype none
interface mvne_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic [7:0]         vert_sel;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic signed [15:0] pos_z;
   logic [7:0]         corner_a;
   logic [7:0]         corner_b;
   logic [7:0]         corner_c;

   modport source (output valid, op, vert_sel, pos_x, pos_y, pos_z,
                   corner_a, corner_b, corner_c, input ready);
   modport sink (input valid, op, vert_sel, pos_x, pos_y, pos_z,
                 corner_a, corner_b, corner_c, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/mvne_rsp_if.sv @@
// Response channel interface of the mesh vertex normal engine
`timescale 1ns / 1ps
`default_nettype none
interface mvne_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;
   logic               degenerate;
   logic               unused_vertex;

   modport source (output valid, kind, normal_x, normal_y, normal_z, degenerate,
                   unused_vertex, input ready);
   modport sink (input valid, kind, normal_x, normal_y, normal_z, degenerate,
                 unused_vertex, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/mvne_front.sv @@
// Front end: accepts requests, range-checks indices and drops empty opcodes
`timescale 1ns / 1ps
`default_nettype none
module mvne_front import mvne_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   mvne_req_if.sink   req_chan,
   input  logic       q_full,
   output logic       q_push,
   output cmd_type    q_data
);

   function automatic logic in_range(input logic [IDX_W-1:0] i);
      return int'(i) < MAX_VERTICES;
   endfunction

   assign req_chan.ready = !q_full;
   assign q_push = req_chan.valid && !q_full && (req_chan.op != OP_NONE);

   always_comb begin
      q_data.op           = req_chan.op;
      q_data.idx          = req_chan.vert_sel;
      q_data.idx_ok       = in_range(req_chan.vert_sel);
      q_data.corner[0]    = req_chan.corner_a;
      q_data.corner[1]    = req_chan.corner_b;
      q_data.corner[2]    = req_chan.corner_c;
      q_data.corner_ok[0] = in_range(req_chan.corner_a);
      q_data.corner_ok[1] = in_range(req_chan.corner_b);
      q_data.corner_ok[2] = in_range(req_chan.corner_c);
      q_data.pos[0]       = req_chan.pos_x;
      q_data.pos[1]       = req_chan.pos_y;
      q_data.pos[2]       = req_chan.pos_z;
   end

endmodule
`default_nettype wire

@@ hw/rtl/mvne_queue.sv @@
// Two-entry command queue between front and back end
`timescale 1ns / 1ps
`default_nettype none
module mvne_queue import mvne_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/mvne_div.sv @@
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module mvne_div import mvne_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [QUO_W-1:0] quo
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [3:0]       step_ff, step_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] lo_ff, lo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [REM_W-1:0] trial;
   logic             fits;

   assign done = done_ff;
   assign quo  = quo_ff;

   always_comb begin
      trial   = {rem_ff[REM_W-2:0], lo_ff[QUO_W-1]};
      fits    = trial >= REM_W'(den_ff);
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         // the quotient is known to fit, so the top bits sit below the divisor
         busy_in = 1'b1;
         step_in = 4'd0;
         rem_in  = REM_W'(num[NUM_W-1:QUO_W]);
         lo_in   = num[QUO_W-1:0];
         den_in  = den;
      end else if (busy_ff) begin
         rem_in  = fits ? trial - REM_W'(den_ff) : trial;
         quo_in  = {quo_ff[QUO_W-2:0], fits};
         lo_in   = {lo_ff[QUO_W-2:0], 1'b0};
         step_in = step_ff + 4'd1;
         if (step_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/mvne_back.sv @@
// Back end: vertex stores, cross product, normalisation and averaging
`timescale 1ns / 1ps
`default_nettype none
module mvne_back import mvne_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int COORD_BITS   = COORD_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  cmd_type q_data,
   output logic    q_pop,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int DW    = COORD_BITS + 1;
   localparam int CW    = 2 * DW + 1;
   localparam int MAGW  = (CW > MAG_LIM + 1) ? CW : MAG_LIM + 1;
   localparam int PW    = 3 * COORD_BITS;
   localparam int SEW   = 3 * SUM_W + CNT_W;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_LOAD   = 4'd1;
   localparam logic [3:0] ST_POS    = 4'd2;
   localparam logic [3:0] ST_MUL    = 4'd3;
   localparam logic [3:0] ST_CHK    = 4'd4;
   localparam logic [3:0] ST_SHIFT  = 4'd5;
   localparam logic [3:0] ST_SQ     = 4'd6;
   localparam logic [3:0] ST_SQRT   = 4'd7;
   localparam logic [3:0] ST_DSTART = 4'd8;
   localparam logic [3:0] ST_DIV    = 4'd9;
   localparam logic [3:0] ST_ACC_RD = 4'd10;
   localparam logic [3:0] ST_ACC_WR = 4'd11;
   localparam logic [3:0] ST_VRD    = 4'd12;
   localparam logic [3:0] ST_VCHK   = 4'd13;
   localparam logic [3:0] ST_OUT    = 4'd14;

   logic [PW-1:0]  pos_mem [MAX_VERTICES];
   logic [SEW-1:0] sum_mem [MAX_VERTICES];
   logic [PW-1:0]  prd_ff;
   logic [SEW-1:0] srd_ff;

   logic [3:0]  state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [1:0]  comp_ff, comp_in;
   cmd_type     cmd_ff, cmd_in;

   logic signed [COORD_BITS-1:0] p_ff [3][3];
   logic signed [COORD_BITS-1:0] p_in [3][3];
   logic signed [CW-1:0]         c_ff [3];
   logic signed [CW-1:0]         c_in [3];
   logic [MAGW-1:0]              m_ff [3];
   logic [MAGW-1:0]              m_in [3];
   logic [2:0]                   neg_ff, neg_in;
   logic signed [2*MUL_W-1:0]    prod_ff, prod_in;
   logic [SQ_W-1:0]              ss_ff, ss_in;
   logic [SQ_W-1:0]              sq_v_ff, sq_v_in;
   logic [SQ_W-1:0]              sq_res_ff, sq_res_in;
   logic [SQ_W-1:0]              sq_bit_ff, sq_bit_in;
   logic [LEN_W-1:0]             len_ff, len_in;
   logic [DEN_W-1:0]             den_ff, den_in;
   logic signed [FIELD_W-1:0]    n_ff [3];
   logic signed [FIELD_W-1:0]    n_in [3];
   logic                         deg_ff, deg_in;
   logic                         unused_ff, unused_in;
   logic                         out_valid_ff, out_valid_in;
   rsp_type                      out_ff, out_in;

   logic signed [DW-1:0]    u [3];
   logic signed [DW-1:0]    v [3];
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic [AW-1:0]           paddr, saddr, waddr;
   logic                    pos_we, sum_we;
   logic [PW-1:0]           pos_wdata;
   logic [SEW-1:0]          sum_wdata;
   logic                    div_start, div_done;
   logic [NUM_W-1:0]        div_num;
   logic [QUO_W-1:0]        div_quo;
   logic [1:0]              jsel;
   logic [2:0]              midx;
   logic [SQ_W-1:0]         trial, res_next;
   logic [CW-1:0]           cabs;
   logic [SUM_W-1:0]        sabs;
   logic [CNT_W-1:0]        rd_cnt;

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;
   assign rd_cnt    = srd_ff[3*SUM_W +: CNT_W];

   mvne_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         u[k] = DW'(p_ff[1][k]) - DW'(p_ff[0][k]);
         v[k] = DW'(p_ff[2][k]) - DW'(p_ff[1][k]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      comp_in      = comp_ff;
      cmd_in       = cmd_ff;
      p_in         = p_ff;
      c_in         = c_ff;
      m_in         = m_ff;
      neg_in       = neg_ff;
      ss_in        = ss_ff;
      sq_v_in      = sq_v_ff;
      sq_res_in    = sq_res_ff;
      sq_bit_in    = sq_bit_ff;
      len_in       = len_ff;
      den_in       = den_ff;
      n_in         = n_ff;
      deg_in       = deg_ff;
      unused_in    = unused_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !out_ready;
      q_pop        = 1'b0;
      pos_we       = 1'b0;
      sum_we       = 1'b0;
      paddr        = '0;
      saddr        = '0;
      waddr        = '0;
      pos_wdata    = '0;
      sum_wdata    = '0;
      div_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      jsel         = cnt_ff[1:0] - 2'd1;
      midx         = cnt_ff[2:0] - 3'd1;
      trial        = sq_res_ff + sq_bit_ff;
      res_next     = '0;
      cabs         = '0;
      sabs         = '0;
      if (cmd_ff.op == OP_READ) begin
         div_num = NUM_W'({m_ff[comp_ff][SUM_W-1:0], 1'b0}) + NUM_W'(len_ff);
      end else begin
         div_num = NUM_W'({m_ff[comp_ff][MAG_LIM-1:0], NORM_SH'(0)}) + NUM_W'(len_ff);
      end

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               cmd_in    = q_data;
               cnt_in    = 5'd0;
               comp_in   = 2'd0;
               deg_in    = 1'b0;
               unused_in = 1'b0;
               for (int k = 0; k < 3; k++) begin
                  n_in[k] = '0;
               end
               case (q_data.op)
                  OP_LOAD: state_in = ST_LOAD;
                  OP_TRI:  state_in = ST_POS;
                  OP_READ: begin
                     if (q_data.idx_ok) begin
                        state_in = ST_VRD;
                     end else begin
                        unused_in = 1'b1;
                        state_in  = ST_OUT;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD: begin
            // store the position, clear sum and count
            waddr = AW'(cmd_ff.idx);
            for (int k = 0; k < 3; k++) begin
               pos_wdata[k*COORD_BITS +: COORD_BITS] = COORD_BITS'(cmd_ff.pos[k]);
            end
            pos_we   = cmd_ff.idx_ok;
            sum_we   = cmd_ff.idx_ok;
            state_in = ST_IDLE;
         end
         ST_POS: begin
            if (cnt_ff < 5'd3) begin
               paddr = AW'(cmd_ff.corner[cnt_ff[1:0]]);
            end
            if (cnt_ff != 5'd0) begin
               for (int k = 0; k < 3; k++) begin
                  p_in[jsel][k] = cmd_ff.corner_ok[jsel] ?
                                  $signed(prd_ff[k*COORD_BITS +: COORD_BITS]) : '0;
               end
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd3) begin
               cnt_in   = 5'd0;
               state_in = ST_MUL;
               for (int k = 0; k < 3; k++) begin
                  c_in[k] = '0;
               end
            end
         end
         ST_MUL: begin
            case (cnt_ff)
               5'd0:    begin mul_a = MUL_W'(u[1]); mul_b = MUL_W'(v[2]); end
               5'd1:    begin mul_a = MUL_W'(u[2]); mul_b = MUL_W'(v[1]); end
               5'd2:    begin mul_a = MUL_W'(u[2]); mul_b = MUL_W'(v[0]); end
               5'd3:    begin mul_a = MUL_W'(u[0]); mul_b = MUL_W'(v[2]); end
               5'd4:    begin mul_a = MUL_W'(u[0]); mul_b = MUL_W'(v[1]); end
               5'd5:    begin mul_a = MUL_W'(u[1]); mul_b = MUL_W'(v[0]); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
            if (cnt_ff != 5'd0) begin
               // even terms add, odd terms subtract
               if (midx[0]) begin
                  c_in[midx[2:1]] = c_ff[midx[2:1]] - CW'(prod_ff);
               end else begin
                  c_in[midx[2:1]] = c_ff[midx[2:1]] + CW'(prod_ff);
               end
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd6) begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (c_ff[0] == '0 && c_ff[1] == '0 && c_ff[2] == '0) begin
               deg_in   = 1'b1;
               comp_in  = 2'd0;
               state_in = ST_ACC_RD;
            end else begin
               for (int k = 0; k < 3; k++) begin
                  cabs      = c_ff[k][CW-1] ? CW'(-c_ff[k]) : CW'(c_ff[k]);
                  m_in[k]   = MAGW'(cabs);
                  neg_in[k] = c_ff[k][CW-1];
               end
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            // shift all magnitudes together until each fits in 30 bits
            if (|(m_ff[0][MAGW-1:MAG_LIM] | m_ff[1][MAGW-1:MAG_LIM] |
                  m_ff[2][MAGW-1:MAG_LIM])) begin
               for (int k = 0; k < 3; k++) begin
                  m_in[k] = m_ff[k] >> 1;
               end
            end else begin
               cnt_in   = 5'd0;
               ss_in    = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            if (cnt_ff < 5'd3) begin
               mul_a = MUL_W'(m_ff[cnt_ff[1:0]][MAG_LIM-1:0]);
               mul_b = MUL_W'(m_ff[cnt_ff[1:0]][MAG_LIM-1:0]);
            end
            if (cnt_ff != 5'd0) begin
               ss_in = ss_ff + SQ_W'(prod_ff);
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd3) begin
               sq_v_in   = ss_ff + SQ_W'(prod_ff);
               sq_res_in = '0;
               sq_bit_in = SQ_W'(1) << SQ_TOP;
               state_in  = ST_SQRT;
            end
         end
         ST_SQRT: begin
            // two bits of the radicand per cycle
            if (sq_v_ff >= trial) begin
               sq_v_in  = sq_v_ff - trial;
               res_next = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               res_next = sq_res_ff >> 1;
            end
            sq_res_in = res_next;
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff[0]) begin
               len_in   = (res_next == '0) ? LEN_W'(1) : LEN_W'(res_next);
               den_in   = (res_next == '0) ? DEN_W'(2) : DEN_W'({res_next, 1'b0});
               comp_in  = 2'd0;
               state_in = ST_DSTART;
            end
         end
         ST_DSTART: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               n_in[comp_ff] = neg_ff[comp_ff] ? $signed(QUO_W'(0) - div_quo)
                                                : $signed(div_quo);
               if (comp_ff == 2'd2) begin
                  comp_in  = 2'd0;
                  state_in = (cmd_ff.op == OP_READ) ? ST_OUT : ST_ACC_RD;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = ST_DSTART;
               end
            end
         end
         ST_ACC_RD: begin
            saddr = AW'(cmd_ff.corner[comp_ff]);
            if (cmd_ff.corner_ok[comp_ff]) begin
               state_in = ST_ACC_WR;
            end else if (comp_ff == 2'd2) begin
               state_in = ST_OUT;
            end else begin
               comp_in = comp_ff + 2'd1;
            end
         end
         ST_ACC_WR: begin
            // a saturated count freezes the whole entry
            waddr = AW'(cmd_ff.corner[comp_ff]);
            for (int k = 0; k < 3; k++) begin
               sum_wdata[k*SUM_W +: SUM_W] = srd_ff[k*SUM_W +: SUM_W] + SUM_W'(n_ff[k]);
            end
            sum_wdata[3*SUM_W +: CNT_W] = rd_cnt + CNT_W'(1);
            sum_we = (rd_cnt != COUNT_MAX);
            if (comp_ff == 2'd2) begin
               state_in = ST_OUT;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = ST_ACC_RD;
            end
         end
         ST_VRD: begin
            saddr    = AW'(cmd_ff.idx);
            state_in = ST_VCHK;
         end
         ST_VCHK: begin
            if (rd_cnt == '0) begin
               unused_in = 1'b1;
               state_in  = ST_OUT;
            end else begin
               for (int k = 0; k < 3; k++) begin
                  sabs      = srd_ff[k*SUM_W + SUM_W - 1] ?
                              SUM_W'(0) - srd_ff[k*SUM_W +: SUM_W] :
                              srd_ff[k*SUM_W +: SUM_W];
                  m_in[k]   = MAGW'(sabs);
                  neg_in[k] = srd_ff[k*SUM_W + SUM_W - 1];
               end
               len_in   = LEN_W'(rd_cnt);
               den_in   = DEN_W'({rd_cnt, 1'b0});
               comp_in  = 2'd0;
               state_in = ST_DSTART;
            end
         end
         ST_OUT: begin
            if (!out_valid_ff || out_ready) begin
               out_valid_in         = 1'b1;
               out_in.kind          = (cmd_ff.op == OP_READ) ? KIND_VERTEX : KIND_FACE;
               out_in.normal[0]     = n_ff[0];
               out_in.normal[1]     = n_ff[1];
               out_in.normal[2]     = n_ff[2];
               out_in.degenerate    = deg_ff;
               out_in.unused_vertex = unused_ff;
               state_in             = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[waddr] <= pos_wdata;
      end
      prd_ff <= pos_mem[paddr];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[waddr] <= sum_wdata;
      end
      srd_ff <= sum_mem[saddr];
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      comp_ff   <= comp_in;
      cmd_ff    <= cmd_in;
      p_ff      <= p_in;
      c_ff      <= c_in;
      m_ff      <= m_in;
      neg_ff    <= neg_in;
      prod_ff   <= prod_in;
      ss_ff     <= ss_in;
      sq_v_ff   <= sq_v_in;
      sq_res_ff <= sq_res_in;
      sq_bit_ff <= sq_bit_in;
      len_ff    <= len_in;
      den_ff    <= den_in;
      n_ff      <= n_in;
      deg_ff    <= deg_in;
      unused_ff <= unused_in;
      out_ff    <= out_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/mesh_vertex_normal_engine.sv @@
// Top level of the mesh vertex normal engine
`timescale 1ns / 1ps
`default_nettype none
// Face and averaged vertex normals for one frame of a triangle mesh. A load
// request stores a vertex position and clears that vertex's normal sum and use
// count; it gives no response. A triangle request reads its three corners,
// forms the cross product of (b-a) and (c-b) over six passes of one 32x32
// multiplier, shifts it down to 30 bits (one bit a cycle), takes an integer
// square root and divides each component by the length on a one-bit-a-cycle
// divider, then adds the Q1.14 face normal into each corner's sum. The square
// root and the shared divider dominate the time a triangle takes from leaving
// the queue to the response register. A zero cross product returns zero with
// the degenerate flag and still counts the corners. A read request returns the
// rounded sum / count, or zero with unused_vertex set for a vertex of count
// zero or an index beyond the store. Counts saturate at 255 and then freeze
// the entry. A two-entry queue decouples request acceptance from the back end,
// and the response sits in an output register, so the next request is taken
// while a response waits. No clearing pass is needed: every store entry is
// defined by its load.
module mesh_vertex_normal_engine import mvne_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int COORD_BITS   = COORD_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mvne_req_if.sink   req_chan,
   mvne_rsp_if.source rsp_chan
);

   // front to queue
   logic    q_push;
   logic    q_full;
   cmd_type q_in_data;

   // queue to back end
   logic    q_pop;
   logic    q_empty;
   cmd_type q_out_data;

   // back end to response channel
   logic    out_valid;
   logic    out_ready;
   rsp_type out_data;

   mvne_front #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in_data)
   );

   mvne_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .empty     (q_empty)
   );

   mvne_back #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_out_data),
      .q_pop     (q_pop),
      .out_valid (out_valid),
      .out_ready (out_ready),
      .out_data  (out_data)
   );

   // drive the response channel straight from the output register
   assign rsp_chan.valid         = out_valid;
   assign out_ready              = rsp_chan.ready;
   assign rsp_chan.kind          = out_data.kind;
   assign rsp_chan.normal_x      = out_data.normal[0];
   assign rsp_chan.normal_y      = out_data.normal[1];
   assign rsp_chan.normal_z      = out_data.normal[2];
   assign rsp_chan.degenerate    = out_data.degenerate;
   assign rsp_chan.unused_vertex = out_data.unused_vertex;

`include "mesh_vertex_normal_engine_assert.svh"

   `MVNE_ASSERT_SAME(a_push_room, clock, reset, q_push, !q_full, "request pushed into a full queue")
   `MVNE_ASSERT_SAME(a_pop_data, clock, reset, q_pop, !q_empty, "back end popped an empty queue")
   `MVNE_ASSERT_NEXT(a_pop_busy, clock, reset, q_pop, !q_pop, "back end popped on consecutive cycles")
   `MVNE_ASSERT_SAME(a_flag_kind, clock, reset, out_valid, (out_data.kind == KIND_FACE) ? !out_data.unused_vertex : !out_data.degenerate, "response flag does not match its kind")

endmodule
`default_nettype wire

@@ tb/mesh_vertex_normal_engine_tb.sv @@
// Self-checking testbench of the mesh vertex normal engine
`timescale 1ns / 1ps
module mesh_vertex_normal_engine_tb;
   import mvne_pkg::*;

   localparam int NVERT   = 256;
   localparam int WD_MAX  = 20000;
   localparam int DRAIN   = 300;

   // one response as the engine should return it
   typedef struct {
      logic              kind;
      logic signed [15:0] nx, ny, nz;
      logic              degenerate;
      logic              unused_vertex;
   } normal_type;

   // one request of the directed table; chk set where the response is typed in
   typedef struct {
      logic [1:0]        op;
      logic [7:0]        vi;
      logic signed [15:0] px, py, pz;
      logic [7:0]        ca, cb, cc;
      bit                chk;
      normal_type        want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mvne_req_if req_chan ();
   mvne_rsp_if rsp_chan ();

   mesh_vertex_normal_engine u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow copy of the engine's stores
   longint  vert_pos [NVERT][3];
   longint  norm_sum [NVERT][3];
   int      use_cnt  [NVERT];
   bit      loaded   [NVERT];

   normal_type pending_normals [$];
   int      errors = 0;
   int      idle_pct = 0;
   int      stall_pct = 0;
   int      quiet_cycles = 0;

   function automatic longint round_div(longint num, longint den);
      longint mag;
      longint q;
      begin
         mag = num < 0 ? -num : num;
         q = (2 * mag + den) / (2 * den);
         return num < 0 ? -q : q;
      end
   endfunction

   function automatic longint int_sqrt(longint v);
      longint res;
      longint bitv;
      begin
         res = 0;
         bitv = 64'sd1 << 62;
         while (bitv > v) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      end
   endfunction

   // work out the response of one accepted request and update the shadow stores
   function automatic void predict_normal(logic [1:0] op, logic [7:0] vi,
                                          logic signed [15:0] px, logic signed [15:0] py,
                                          logic signed [15:0] pz, logic [7:0] ca,
                                          logic [7:0] cb, logic [7:0] cc);
      longint  p [3][3];
      longint  u [3], v [3], c [3], m [3], n [3];
      longint  mx, len;
      int      sh;
      logic [7:0] ci [3];
      normal_type r;
      begin
         if (op == OP_LOAD) begin
            vert_pos[vi][0] = px;
            vert_pos[vi][1] = py;
            vert_pos[vi][2] = pz;
            for (int k = 0; k < 3; k++) norm_sum[vi][k] = 0;
            use_cnt[vi] = 0;
            loaded[vi] = 1'b1;
         end else if (op == OP_TRI) begin
            ci[0] = ca; ci[1] = cb; ci[2] = cc;
            for (int j = 0; j < 3; j++)
               for (int k = 0; k < 3; k++) p[j][k] = vert_pos[ci[j]][k];
            for (int k = 0; k < 3; k++) begin
               u[k] = p[1][k] - p[0][k];
               v[k] = p[2][k] - p[1][k];
            end
            c[0] = u[1] * v[2] - u[2] * v[1];
            c[1] = u[2] * v[0] - u[0] * v[2];
            c[2] = u[0] * v[1] - u[1] * v[0];
            r.degenerate = (c[0] == 0 && c[1] == 0 && c[2] == 0);
            if (r.degenerate) begin
               n[0] = 0; n[1] = 0; n[2] = 0;
            end else begin
               for (int k = 0; k < 3; k++) m[k] = c[k] < 0 ? -c[k] : c[k];
               mx = m[0];
               if (m[1] > mx) mx = m[1];
               if (m[2] > mx) mx = m[2];
               sh = 0;
               while ((mx >> sh) >= (64'sd1 << 30)) sh++;
               for (int k = 0; k < 3; k++) m[k] = m[k] >> sh;
               len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
               if (len == 0) len = 1;
               for (int k = 0; k < 3; k++)
                  n[k] = round_div(c[k] < 0 ? -(m[k] * 16384) : m[k] * 16384, len);
            end
            // each corner slot accumulates in turn; saturated entries freeze
            for (int j = 0; j < 3; j++)
               if (use_cnt[ci[j]] < COUNT_MAX) begin
                  for (int k = 0; k < 3; k++) norm_sum[ci[j]][k] += n[k];
                  use_cnt[ci[j]]++;
               end
            r.kind = KIND_FACE;
            r.nx = 16'(n[0]); r.ny = 16'(n[1]); r.nz = 16'(n[2]);
            r.unused_vertex = 1'b0;
            pending_normals.push_back(r);
         end else if (op == OP_READ) begin
            r.kind = KIND_VERTEX;
            r.degenerate = 1'b0;
            r.unused_vertex = (use_cnt[vi] == 0);
            r.nx = '0; r.ny = '0; r.nz = '0;
            if (!r.unused_vertex) begin
               r.nx = 16'(round_div(norm_sum[vi][0], use_cnt[vi]));
               r.ny = 16'(round_div(norm_sum[vi][1], use_cnt[vi]));
               r.nz = 16'(round_div(norm_sum[vi][2], use_cnt[vi]));
            end
            pending_normals.push_back(r);
         end
      end
   endfunction

   // idle at the current rate, then hold the request until accepted
   task automatic send_request(logic [1:0] op, logic [7:0] vi, logic signed [15:0] px,
                               logic signed [15:0] py, logic signed [15:0] pz,
                               logic [7:0] ca, logic [7:0] cb, logic [7:0] cc);
      begin
         while ($urandom_range(99) < idle_pct) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
         req_chan.valid        <= 1'b1;
         req_chan.op           <= op;
         req_chan.vert_sel     <= vi;
         req_chan.pos_x        <= px;
         req_chan.pos_y        <= py;
         req_chan.pos_z        <= pz;
         req_chan.corner_a     <= ca;
         req_chan.corner_b     <= cb;
         req_chan.corner_c     <= cc;
         @(posedge clock);
         while (!req_chan.ready) @(posedge clock);
         predict_normal(op, vi, px, py, pz, ca, cb, cc);
      end
   endtask

   function automatic logic signed [15:0] rand_coord();
      begin
         case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(15) - 8);
            2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom_range(511) - 256);
         endcase
      end
   endfunction

   // compare each response with the oldest expectation
   always @(posedge clock) begin
      normal_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_normals.size() == 0) begin
            $display("%0t: unexpected response kind=%0b n=(%0d,%0d,%0d)", $time,
                     rsp_chan.kind, rsp_chan.normal_x, rsp_chan.normal_y,
                     rsp_chan.normal_z);
            errors++;
         end else begin
            want = pending_normals.pop_front();
            if (rsp_chan.kind !== want.kind || rsp_chan.normal_x !== want.nx ||
                rsp_chan.normal_y !== want.ny || rsp_chan.normal_z !== want.nz ||
                rsp_chan.degenerate !== want.degenerate ||
                rsp_chan.unused_vertex !== want.unused_vertex) begin
               $display("%0t: mismatch expected kind=%0b n=(%0d,%0d,%0d) deg=%0b unused=%0b",
                        $time, want.kind, want.nx, want.ny, want.nz, want.degenerate,
                        want.unused_vertex);
               $display("%0t:          actual kind=%0b n=(%0d,%0d,%0d) deg=%0b unused=%0b",
                        $time, rsp_chan.kind, rsp_chan.normal_x, rsp_chan.normal_y,
                        rsp_chan.normal_z, rsp_chan.degenerate, rsp_chan.unused_vertex);
               errors++;
            end
         end
      end
   end

   // stall the receiver at the current rate
   always @(posedge clock)
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);

   // watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_MAX) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   dir_row_type dir_rows [$];

   function automatic dir_row_type mk_row(logic [1:0] op, logic [7:0] vi, int px, int py,
                                          int pz, logic [7:0] ca, logic [7:0] cb,
                                          logic [7:0] cc, bit chk, logic kind, int nx,
                                          int ny, int nz, logic dg, logic un);
      dir_row_type r;
      begin
         r.op = op; r.vi = vi; r.px = 16'(px); r.py = 16'(py); r.pz = 16'(pz);
         r.ca = ca; r.cb = cb; r.cc = cc; r.chk = chk;
         r.want.kind = kind; r.want.nx = 16'(nx); r.want.ny = 16'(ny);
         r.want.nz = 16'(nz);
         r.want.degenerate = dg; r.want.unused_vertex = un;
         return r;
      end
   endfunction

   initial begin
      logic [1:0] op;
      logic [7:0] vi, a, b, c;
      int         n_items;
      req_chan.valid <= 1'b0;
      req_chan.op <= OP_NONE;
      req_chan.vert_sel <= '0;
      req_chan.pos_x <= '0;
      req_chan.pos_y <= '0;
      req_chan.pos_z <= '0;
      req_chan.corner_a <= '0;
      req_chan.corner_b <= '0;
      req_chan.corner_c <= '0;
      for (int i = 0; i < NVERT; i++) begin
         loaded[i] = 1'b0;
         use_cnt[i] = 0;
         for (int k = 0; k < 3; k++) begin
            vert_pos[i][k] = 0;
            norm_sum[i][k] = 0;
         end
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table: unit triangle, extremes, degenerate, repeated corner
      dir_rows.push_back(mk_row(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(OP_LOAD, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(OP_LOAD, 2, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, KIND_VERTEX, 0, 0, 0, 0, 1));
      dir_rows.push_back(mk_row(OP_TRI, 0, 0, 0, 0, 0, 1, 2, 1, KIND_FACE, 0, 0, 16384, 0, 0));
      dir_rows.push_back(mk_row(OP_READ, 1, 0, 0, 0, 0, 0, 0, 1, KIND_VERTEX, 0, 0, 16384, 0, 0));
      dir_rows.push_back(mk_row(OP_TRI, 0, 0, 0, 0, 2, 1, 0, 1, KIND_FACE, 0, 0, -16384, 0, 0));
      dir_rows.push_back(mk_row(OP_TRI, 0, 0, 0, 0, 1, 1, 2, 1, KIND_FACE, 0, 0, 0, 1, 0));
      dir_rows.push_back(mk_row(OP_NONE, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(OP_LOAD, 255, 32767, -32768, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(OP_LOAD, 254, -32768, 32767, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(OP_LOAD, 253, 32767, 32767, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(OP_TRI, 0, 0, 0, 0, 255, 254, 253, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(OP_TRI, 0, 0, 0, 0, 253, 255, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(OP_TRI, 0, 0, 0, 0, 0, 0, 2, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(OP_READ, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(OP_READ, 253, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      foreach (dir_rows[i]) begin
         send_request(dir_rows[i].op, dir_rows[i].vi, dir_rows[i].px, dir_rows[i].py,
                      dir_rows[i].pz, dir_rows[i].ca, dir_rows[i].cb, dir_rows[i].cc);
         if (dir_rows[i].chk && (dir_rows[i].op == OP_TRI || dir_rows[i].op == OP_READ))
            pending_normals[$] = dir_rows[i].want;
      end

      // load every vertex so that no unwritten entry is read afterwards
      for (int i = 0; i < NVERT; i++)
         send_request(OP_LOAD, 8'(i), rand_coord(), rand_coord(), rand_coord(),
                      8'd0, 8'd0, 8'd0);

      // random phases: no idling, sender idle, receiver stalling, both
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = (phase == 1) ? 70 : (phase == 3) ? 13 : 0;
         stall_pct = (phase == 2) ? 70 : (phase == 3) ? 13 : 0;
         n_items = 390;
         for (int i = 0; i < n_items; i++) begin
            op = $urandom_range(99) < 15 ? OP_LOAD :
                 $urandom_range(99) < 65 ? OP_TRI  :
                 $urandom_range(99) < 95 ? OP_READ : OP_NONE;
            vi = 8'($urandom);
            a = 8'($urandom);
            b = $urandom_range(3) == 0 ? a : 8'($urandom);
            c = 8'($urandom);
            // hammer one vertex to drive its count into saturation, reading it now and then
            if (phase == 0 && i < 300) begin
               op = (i % 10 == 9) ? OP_READ : OP_TRI;
               vi = 8'd7;
               a = 8'd7;
               b = 8'($urandom_range(20, 8));
               c = 8'($urandom_range(40, 21));
            end
            send_request(op, vi, rand_coord(), rand_coord(), rand_coord(), a, b, c);
         end
         // hold off until everything outstanding has come back
         req_chan.valid <= 1'b0;
         @(posedge clock);
         while (pending_normals.size() != 0) @(posedge clock);
      end

      repeat (DRAIN) @(posedge clock);
      if (errors == 0 && pending_normals.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
